>>> rtl/npcm_pkg.sv
// Shared constants for the nearest palette color match block.
// No dependencies; used by nearest_palette_color_match_top.
package npcm_pkg;

  // Widths of the port fields
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // Request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Distance weights: 3*dr^2 + 4*dg^2 + 2*db^2
  localparam int unsigned WEIGHT_R = 3;
  localparam int unsigned WEIGHT_G = 4;
  localparam int unsigned WEIGHT_B = 2;

endpackage

>>> rtl/nearest_palette_color_match_top.sv
// Nearest palette color match: palette memory, distance pipeline and scan sequencer.
// Depends on npcm_pkg.
//
// A write request (func 0) stores one palette entry and gives no result. A query
// request (func 1) walks entries 0 .. cell_count-1 (capped at PALETTE_DEPTH), one
// palette memory read per cycle, through a four-stage distance unit (read, channel
// differences, squares, weighted sum) and a running minimum; the first entry with
// the strictly smallest distance wins. in_stall is high from the accepted query
// until its result is loaded into the output register. With cell_count 0 the query
// goes straight to the finish state and its color comes back with found 0. An entry
// must be written before a query reads it. Write requests are taken while a
// finished result waits on the output.
module nearest_palette_color_match_top #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned CHANNEL_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npcm_pkg::COUNT_W-1:0]      cfg_cell_count,
  // requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [npcm_pkg::INDEX_W-1:0]      in_entry_index,
  input  logic [npcm_pkg::COLOR_W-1:0]      in_red_in,
  input  logic [npcm_pkg::COLOR_W-1:0]      in_green_in,
  input  logic [npcm_pkg::COLOR_W-1:0]      in_blue_in,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [npcm_pkg::INDEX_W-1:0]      out_match_index,
  output logic [npcm_pkg::COLOR_W-1:0]      out_match_red,
  output logic [npcm_pkg::COLOR_W-1:0]      out_match_green,
  output logic [npcm_pkg::COLOR_W-1:0]      out_match_blue,
  output logic                              out_found
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned SW = 2 * CB;
  localparam int unsigned DW = 2 * CB + 4;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [npcm_pkg::COUNT_W-1:0] cell_count_r;

  logic [3*CB-1:0] palette_r [PALETTE_DEPTH];

  logic          in_acc;
  logic          wr_en;
  logic [31:0]   wr_idx32;
  logic [CW-1:0] n_sat;

  logic [CB-1:0] q_r_r, q_g_r, q_b_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] addr_r;
  logic          issue;
  logic          pipe_busy;

  // stage 1: memory read
  logic          v1_r;
  logic [AW-1:0] idx1_r;
  logic [3*CB-1:0] rd_data_r;
  // stage 2: channel differences
  logic          v2_r;
  logic [AW-1:0] idx2_r;
  logic [3*CB-1:0] col2_r;
  logic [CB-1:0] dr_r, dg_r, db_r;
  // stage 3: squares
  logic          v3_r;
  logic [AW-1:0] idx3_r;
  logic [3*CB-1:0] col3_r;
  logic [SW-1:0] sr_r, sg_r, sb_r;
  // stage 4: weighted sum
  logic          v4_r;
  logic [AW-1:0] idx4_r;
  logic [3*CB-1:0] col4_r;
  logic [DW-1:0] dist_r;

  // running minimum
  logic          have_r;
  logic [DW-1:0] best_d_r;
  logic [AW-1:0] best_idx_r;
  logic [3*CB-1:0] best_col_r;

  logic          out_valid_r;
  logic          out_load;
  logic [npcm_pkg::INDEX_W-1:0] out_index_r;
  logic [npcm_pkg::COLOR_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic          out_found_r;
  logic [31:0]   best_idx32;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign wr_idx32  = 32'(in_entry_index);
  assign wr_en     = in_acc && (in_func == npcm_pkg::FUNC_WRITE) &&
                     (wr_idx32 < 32'(PALETTE_DEPTH));

  assign n_sat = (32'(cell_count_r) > 32'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                           : CW'(cell_count_r);

  assign issue     = (state_r == ST_SCAN) && (addr_r < n_r);
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= npcm_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cell_count_r <= cfg_cell_count;
    end
  end

  // palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_r[wr_idx32[AW-1:0]] <= {in_red_in[CB-1:0], in_green_in[CB-1:0],
                                      in_blue_in[CB-1:0]};
    end
    if (issue) begin
      rd_data_r <= palette_r[addr_r[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == npcm_pkg::FUNC_QUERY)) begin
          state_nxt = (n_sat == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !pipe_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      have_r  <= 1'b0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      if (in_acc && (in_func == npcm_pkg::FUNC_QUERY)) begin
        addr_r <= '0;
        have_r <= 1'b0;
      end else begin
        if (issue) begin
          addr_r <= addr_r + CW'(1);
        end
        // strict compare keeps the lowest index on a tie
        if (v4_r && (!have_r || (dist_r < best_d_r))) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  // query capture and datapath
  always_ff @(posedge clk) begin
    if (in_acc && (in_func == npcm_pkg::FUNC_QUERY)) begin
      q_r_r <= in_red_in[CB-1:0];
      q_g_r <= in_green_in[CB-1:0];
      q_b_r <= in_blue_in[CB-1:0];
      n_r   <= n_sat;
    end
    if (issue) begin
      idx1_r <= addr_r[AW-1:0];
    end
    idx2_r <= idx1_r;
    col2_r <= rd_data_r;
    dr_r   <= abs_diff(q_r_r, rd_data_r[3*CB-1:2*CB]);
    dg_r   <= abs_diff(q_g_r, rd_data_r[2*CB-1:CB]);
    db_r   <= abs_diff(q_b_r, rd_data_r[CB-1:0]);

    idx3_r <= idx2_r;
    col3_r <= col2_r;
    sr_r   <= SW'(dr_r) * SW'(dr_r);
    sg_r   <= SW'(dg_r) * SW'(dg_r);
    sb_r   <= SW'(db_r) * SW'(db_r);

    idx4_r <= idx3_r;
    col4_r <= col3_r;
    dist_r <= DW'(DW'(sr_r) * DW'(npcm_pkg::WEIGHT_R)) +
              DW'(DW'(sg_r) * DW'(npcm_pkg::WEIGHT_G)) +
              DW'(DW'(sb_r) * DW'(npcm_pkg::WEIGHT_B));

    if (v4_r && (!have_r || (dist_r < best_d_r))) begin
      best_d_r   <= dist_r;
      best_idx_r <= idx4_r;
      best_col_r <= col4_r;
    end
  end

  assign best_idx32 = 32'(best_idx_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= have_r;
      if (have_r) begin
        out_index_r <= best_idx32[npcm_pkg::INDEX_W-1:0];
        out_red_r   <= npcm_pkg::COLOR_W'(best_col_r[3*CB-1:2*CB]);
        out_green_r <= npcm_pkg::COLOR_W'(best_col_r[2*CB-1:CB]);
        out_blue_r  <= npcm_pkg::COLOR_W'(best_col_r[CB-1:0]);
      end else begin
        out_index_r <= '0;
        out_red_r   <= npcm_pkg::COLOR_W'(q_r_r);
        out_green_r <= npcm_pkg::COLOR_W'(q_g_r);
        out_blue_r  <= npcm_pkg::COLOR_W'(q_b_r);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_index_r;
  assign out_match_red   = out_red_r;
  assign out_match_green = out_green_r;
  assign out_match_blue  = out_blue_r;
  assign out_found       = out_found_r;

`ifndef SYNTHESIS
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared without a finished scan");

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(v1_r || v2_r || v3_r || v4_r))
    else $error("distance pipeline busy while idle");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (addr_r <= n_r))
    else $error("scan address ran past the entry count");

  a_not_found_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_index_r == '0))
    else $error("nonzero index on an empty search");
`endif

endmodule

>>> test/tb_nearest_palette_color_match_top.sv
// Self-checking testbench for nearest_palette_color_match_top.
// Needs npcm_pkg and the top level; a scoreboard predicts every query from its own palette copy.
`timescale 1ns / 1ps

module tb_nearest_palette_color_match_top;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 270;

  typedef struct packed {
    logic [npcm_pkg::INDEX_W-1:0] index;
    logic [npcm_pkg::COLOR_W-1:0] red;
    logic [npcm_pkg::COLOR_W-1:0] green;
    logic [npcm_pkg::COLOR_W-1:0] blue;
    logic                         found;
  } match_t;

  typedef enum int {PICK_RANDOM, PICK_COPY, PICK_NEAR, PICK_EXTREME} color_pick_t;

  class palette_scoreboard_t;
    logic [npcm_pkg::COLOR_W-1:0] pal_r[DEPTH];
    logic [npcm_pkg::COLOR_W-1:0] pal_g[DEPTH];
    logic [npcm_pkg::COLOR_W-1:0] pal_b[DEPTH];
    int unsigned        cell_count;
    match_t             expected_q[$];
    int unsigned        mismatches, writes, queries, results, found_hits;

    function new();
      cell_count = npcm_pkg::COUNT_RESET;
      foreach (pal_r[i]) begin
        pal_r[i] = '0;
        pal_g[i] = '0;
        pal_b[i] = '0;
      end
    endfunction

    function void set_cell_count(logic [npcm_pkg::COUNT_W-1:0] v);
      cell_count = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Writes update the palette copy; queries scan it for the nearest entry.
    function void note_request(logic func, logic [npcm_pkg::INDEX_W-1:0] idx,
                               logic [npcm_pkg::COLOR_W-1:0] r,
                               logic [npcm_pkg::COLOR_W-1:0] g,
                               logic [npcm_pkg::COLOR_W-1:0] b);
      match_t            want;
      longint unsigned   best_d, d, dr, dg, db;
      int unsigned       n;
      bit                have;
      if (func == npcm_pkg::FUNC_WRITE) begin
        pal_r[idx] = r;
        pal_g[idx] = g;
        pal_b[idx] = b;
        writes++;
        return;
      end
      queries++;
      n = (cell_count > DEPTH) ? DEPTH : cell_count;
      have = 1'b0;
      best_d = 0;
      want = '{index: '0, red: r, green: g, blue: b, found: 1'b0};
      for (int unsigned j = 0; j < n; j++) begin
        dr = (r >= pal_r[j]) ? r - pal_r[j] : pal_r[j] - r;
        dg = (g >= pal_g[j]) ? g - pal_g[j] : pal_g[j] - g;
        db = (b >= pal_b[j]) ? b - pal_b[j] : pal_b[j] - b;
        d = npcm_pkg::WEIGHT_R * dr * dr + npcm_pkg::WEIGHT_G * dg * dg +
            npcm_pkg::WEIGHT_B * db * db;
        // strict compare: ties keep the lower index
        if (!have || d < best_d) begin
          have = 1'b1;
          best_d = d;
          want = '{index: 8'(j), red: pal_r[j], green: pal_g[j], blue: pal_b[j],
                   found: 1'b1};
        end
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(match_t got);
      match_t want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d rgb %h %h %h found %0b",
                   got.index, got.red, got.green, got.blue, got.found);
        return;
      end
      want = expected_q.pop_front();
      if (got.index !== want.index || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.found !== want.found) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected idx %0d rgb %h %h %h found %0b, ",
                    "got idx %0d rgb %h %h %h found %0b"},
                   want.index, want.red, want.green, want.blue, want.found,
                   got.index, got.red, got.green, got.blue, got.found);
      end else if (got.found) begin
        found_hits++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [npcm_pkg::COUNT_W-1:0]   cfg_cell_count = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_func = npcm_pkg::FUNC_WRITE;
  logic [npcm_pkg::INDEX_W-1:0]   in_entry_index = '0;
  logic [npcm_pkg::COLOR_W-1:0]   in_red_in = '0;
  logic [npcm_pkg::COLOR_W-1:0]   in_green_in = '0;
  logic [npcm_pkg::COLOR_W-1:0]   in_blue_in = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [npcm_pkg::INDEX_W-1:0]   out_match_index;
  logic [npcm_pkg::COLOR_W-1:0]   out_match_red;
  logic [npcm_pkg::COLOR_W-1:0]   out_match_green;
  logic [npcm_pkg::COLOR_W-1:0]   out_match_blue;
  logic                           out_found;

  palette_scoreboard_t  sb;
  bit                   written[DEPTH];
  int unsigned          gen_count = npcm_pkg::COUNT_RESET;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;
  bit                   hold_req = 1'b0;
  int unsigned          hold_left = 0;
  int unsigned          cycle_count = 0;
  int unsigned          settings_used = 0;

  nearest_palette_color_match_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_cell_count  (cfg_cell_count),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_index (out_match_index),
    .out_match_red   (out_match_red),
    .out_match_green (out_match_green),
    .out_match_blue  (out_match_blue),
    .out_found       (out_found)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: sample the handshake, then pick the next stall value.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall)
      sb.check_result('{index: out_match_index, red: out_match_red, green: out_match_green,
                        blue: out_match_blue, found: out_found});
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic logic [npcm_pkg::COLOR_W-1:0] jitter(logic [npcm_pkg::COLOR_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 600)) - 300;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[npcm_pkg::COLOR_W-1:0];
  endfunction

  task automatic make_color(input color_pick_t pick, input int unsigned j,
                            output logic [npcm_pkg::COLOR_W-1:0] r,
                            output logic [npcm_pkg::COLOR_W-1:0] g,
                            output logic [npcm_pkg::COLOR_W-1:0] b);
    color_pick_t p;
    p = pick;
    if ((p == PICK_COPY || p == PICK_NEAR) && !written[j]) p = PICK_RANDOM;
    case (p)
      PICK_COPY: begin
        r = sb.pal_r[j];
        g = sb.pal_g[j];
        b = sb.pal_b[j];
      end
      PICK_NEAR: begin
        r = jitter(sb.pal_r[j]);
        g = jitter(sb.pal_g[j]);
        b = jitter(sb.pal_b[j]);
      end
      PICK_EXTREME: begin
        r = {npcm_pkg::COLOR_W{1'($urandom_range(0, 1))}};
        g = {npcm_pkg::COLOR_W{1'($urandom_range(0, 1))}};
        b = {npcm_pkg::COLOR_W{1'($urandom_range(0, 1))}};
      end
      default: begin
        r = 16'($urandom);
        g = 16'($urandom);
        b = 16'($urandom);
      end
    endcase
  endtask

  task automatic send_request(input logic func, input logic [npcm_pkg::INDEX_W-1:0] idx,
                              input logic [npcm_pkg::COLOR_W-1:0] r,
                              input logic [npcm_pkg::COLOR_W-1:0] g,
                              input logic [npcm_pkg::COLOR_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_entry_index <= idx;
    in_red_in      <= r;
    in_green_in    <= g;
    in_blue_in     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(func, idx, r, g, b);
    if (func == npcm_pkg::FUNC_WRITE) written[idx] = 1'b1;
  endtask

  // Register writes only with the block idle and every result back.
  task automatic set_cell_count(input logic [npcm_pkg::COUNT_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_cell_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_cell_count(v);
    gen_count = v;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic fill_palette();
    logic [npcm_pkg::COLOR_W-1:0] r, g, b;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (!written[i]) begin
        make_color(($urandom_range(0, 3) == 0) ? PICK_EXTREME : PICK_RANDOM, 0, r, g, b);
        send_request(npcm_pkg::FUNC_WRITE, 8'(i), r, g, b);
      end
    end
  endtask

  // Mostly writes in or just past the searched range; queries use random, stored,
  // near or extreme colors. Unwritten entries in range get written before a query.
  task automatic run_phase(input int unsigned n_items);
    int unsigned                  eff, gap, j, top;
    color_pick_t                  pick;
    logic                         func;
    logic [npcm_pkg::INDEX_W-1:0] idx;
    logic [npcm_pkg::COLOR_W-1:0] r, g, b;
    eff = (gen_count > DEPTH) ? DEPTH : gen_count;
    top = (eff + 1 < DEPTH) ? eff + 1 : DEPTH - 1;
    repeat (n_items) begin
      gap = eff;
      for (int unsigned k = 0; k < eff; k++) begin
        if (!written[k]) begin
          gap = k;
          break;
        end
      end
      j = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
      pick = color_pick_t'($urandom_range(0, 3));
      if (gap < eff) begin
        func = npcm_pkg::FUNC_WRITE;
        idx = 8'(gap);
        make_color(PICK_RANDOM, 0, r, g, b);
      end else if ($urandom_range(0, 99) < 45) begin
        func = npcm_pkg::FUNC_QUERY;
        idx = 8'($urandom);
        make_color(pick, j, r, g, b);
      end else begin
        func = npcm_pkg::FUNC_WRITE;
        idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, top));
        make_color(pick, j, r, g, b);
      end
      send_request(func, idx, r, g, b);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme colors, a tie pair, the top index, empty search
    set_idle(11, 86);
    send_request(npcm_pkg::FUNC_WRITE, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(npcm_pkg::FUNC_WRITE, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(npcm_pkg::FUNC_WRITE, 8'd2, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_request(npcm_pkg::FUNC_WRITE, 8'd3, 16'h0000, 16'hFFFF, 16'h0000);
    send_request(npcm_pkg::FUNC_WRITE, 8'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(npcm_pkg::FUNC_WRITE, 8'd255, 16'h1234, 16'h8000, 16'h7FFF);
    set_cell_count(9'd0);
    send_request(npcm_pkg::FUNC_QUERY, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_request(npcm_pkg::FUNC_QUERY, 8'd255, 16'h0000, 16'h0000, 16'h0001);
    set_cell_count(9'd5);
    send_request(npcm_pkg::FUNC_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(npcm_pkg::FUNC_QUERY, 8'd7, 16'h0000, 16'h0000, 16'h0000);
    send_request(npcm_pkg::FUNC_QUERY, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_request(npcm_pkg::FUNC_QUERY, 8'd0, 16'h8000, 16'h8000, 16'h8000);
    send_request(npcm_pkg::FUNC_QUERY, 8'd0, 16'h0000, 16'hFFFF, 16'h0000);
    send_request(npcm_pkg::FUNC_WRITE, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(npcm_pkg::FUNC_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_cell_count(9'd1);
    send_request(npcm_pkg::FUNC_QUERY, 8'd128, 16'h0001, 16'h0002, 16'h0003);

    // random, slow receiver side first
    set_cell_count(9'd2);
    run_phase(120);
    set_cell_count(9'd7);
    hold_req = 1'b1;   // long output back-pressure while requests keep coming
    run_phase(150);
    set_cell_count(9'd1);
    run_phase(80);
    set_cell_count(9'd0);
    run_phase(40);
    set_cell_count(9'd16);
    run_phase(150);

    set_idle(86, 11);
    set_cell_count(9'd3);
    run_phase(100);
    fill_palette();
    set_cell_count(9'd256);
    run_phase(25);
    set_cell_count(9'd511);
    run_phase(15);
    set_cell_count(9'd257);
    run_phase(10);

    set_idle(0, 0);
    set_cell_count(9'd40);
    run_phase(150);
    set_cell_count(9'd9);
    run_phase(150);
    set_cell_count(9'd100);
    run_phase(40);
    set_cell_count(9'd5);
    run_phase(150);
    set_cell_count(9'd12);
    run_phase(150);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d palette writes and %0d queries over %0d cell-count settings",
             sb.writes, sb.queries, settings_used);
    $display("%0d results checked (%0d with a match), %0d mismatches, %0d still pending",
             sb.results, sb.found_hits, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/npcm_pkg.sv
rtl/nearest_palette_color_match_top.sv
test/tb_nearest_palette_color_match_top.sv
